[rtl/core/i2d_pkg.sv]
// Package for the decimal text converter: widths, character codes, the
// microcode word layout and the control/status structs between sequencer
// and datapath. No dependencies.
package i2d_pkg;

  localparam int VALUE_W     = 32;
  localparam int CHAR_W      = 8;
  localparam int TOTAL_W     = 4;
  localparam int MAX_DIGITS  = 10;
  localparam int DIG_IDX_W   = 4;
  localparam int PROD_W      = 2 * VALUE_W;
  localparam int RECIP_SHIFT = 35;

  // floor(x * RECIP_10 / 2**35) equals floor(x / 10) for every 32-bit x.
  localparam logic [VALUE_W-1:0] RECIP_10   = 32'hCCCC_CCCD;
  localparam logic [CHAR_W-1:0]  DIGIT_BASE = 8'd48;
  localparam logic [CHAR_W-1:0]  MINUS_CODE = 8'd45;

  localparam logic OPC_SIGNED   = 1'b0;
  localparam logic OPC_UNSIGNED = 1'b1;

  localparam int PC_W = 3;
  typedef logic [PC_W-1:0] pc_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_MUL,
    OP_DIV,
    OP_EMIT_SIGN,
    OP_EMIT_DIGIT
  } dp_op_t;

  typedef enum logic [1:0] {
    HOLD_NONE,
    HOLD_INPUT,
    HOLD_OUTPUT
  } hold_t;

  typedef enum logic [1:0] {
    BR_NEVER,
    BR_QUOT_NZ,
    BR_MORE_DIG
  } br_t;

  typedef struct packed {
    dp_op_t op;
    hold_t  hold;
    br_t    br;
    pc_t    br_pc;
    pc_t    next_pc;
  } uword_t;

  typedef struct packed {
    dp_op_t op;
    logic   go;
  } dp_ctl_t;

  typedef struct packed {
    logic in_avail;
    logic out_free;
    logic neg;
    logic quot_nz;
    logic more_dig;
  } dp_stat_t;

endpackage

[rtl/core/i2d_if.sv]
// Handshake interfaces for the input word and the output character channels.
// Depends on i2d_pkg for field widths.
interface i2d_in_if;
  logic                        valid;
  logic                        ready;
  logic                        opcode;
  logic [i2d_pkg::VALUE_W-1:0] value;

  modport source(output valid, output opcode, output value, input ready);
  modport sink(input valid, input opcode, input value, output ready);
endinterface

interface i2d_out_if;
  logic                        valid;
  logic                        ready;
  logic [i2d_pkg::CHAR_W-1:0]  char_code;
  logic                        is_last;
  logic [i2d_pkg::TOTAL_W-1:0] char_total;

  modport source(output valid, output char_code, output is_last, output char_total,
                 input ready);
  modport sink(input valid, input char_code, input is_last, input char_total,
               output ready);
endinterface

[rtl/core/i2d_seq.sv]
// Microcode sequencer: step counter, control store and branch/hold logic.
// Depends on i2d_pkg.
module i2d_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  i2d_pkg::dp_stat_t stat,
  output i2d_pkg::dp_ctl_t  ctl
);
  import i2d_pkg::*;

  pc_t    pc_r;
  pc_t    pc_nxt;
  uword_t uw;
  logic   hold;
  logic   taken;

  // Control store.
  always_comb begin
    unique case (pc_r)
      3'd0:    uw = '{op: OP_LOAD,       hold: HOLD_INPUT,  br: BR_NEVER,
                      br_pc: 3'd0, next_pc: 3'd1};
      3'd1:    uw = '{op: OP_MUL,        hold: HOLD_NONE,   br: BR_NEVER,
                      br_pc: 3'd0, next_pc: 3'd2};
      3'd2:    uw = '{op: OP_DIV,        hold: HOLD_NONE,   br: BR_QUOT_NZ,
                      br_pc: 3'd1, next_pc: 3'd3};
      3'd3:    uw = '{op: OP_EMIT_SIGN,  hold: HOLD_OUTPUT, br: BR_NEVER,
                      br_pc: 3'd0, next_pc: 3'd4};
      3'd4:    uw = '{op: OP_EMIT_DIGIT, hold: HOLD_OUTPUT, br: BR_MORE_DIG,
                      br_pc: 3'd4, next_pc: 3'd0};
      default: uw = '{op: OP_NOP,        hold: HOLD_NONE,   br: BR_NEVER,
                      br_pc: 3'd0, next_pc: 3'd0};
    endcase
  end

  always_comb begin
    unique case (uw.hold)
      HOLD_INPUT:  hold = !stat.in_avail;
      // The sign step only needs the output slot when there is a sign to send.
      HOLD_OUTPUT: hold = !stat.out_free && (uw.op != OP_EMIT_SIGN || stat.neg);
      default:     hold = 1'b0;
    endcase
  end

  always_comb begin
    unique case (uw.br)
      BR_QUOT_NZ:  taken = stat.quot_nz;
      BR_MORE_DIG: taken = stat.more_dig;
      default:     taken = 1'b0;
    endcase
  end

  always_comb begin
    if (hold) begin
      pc_nxt = pc_r;
    end else if (taken) begin
      pc_nxt = uw.br_pc;
    end else begin
      pc_nxt = uw.next_pc;
    end
  end

  assign ctl.op = uw.op;
  assign ctl.go = !hold;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= '0;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

[rtl/core/i2d_dp.sv]
// Datapath: magnitude register, reciprocal multiplier, digit buffer and
// output register. Driven by control words from i2d_seq. Depends on i2d_pkg
// and the channel interfaces.
module i2d_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  i2d_pkg::dp_ctl_t  ctl,
  output i2d_pkg::dp_stat_t stat,
  i2d_in_if.sink            in_ch,
  i2d_out_if.source         out_ch
);
  import i2d_pkg::*;

  logic [VALUE_W-1:0]   mag_r;
  logic [PROD_W-1:0]    prod_r;
  logic                 neg_r;
  logic [DIG_IDX_W-1:0] nd_r;
  logic [TOTAL_W-1:0]   total_r;
  logic [3:0]           dig_r [MAX_DIGITS];

  logic [CHAR_W-1:0]    out_char_r;
  logic                 out_last_r;
  logic [TOTAL_W-1:0]   out_total_r;
  logic                 out_valid_r;

  logic                 in_neg;
  logic [VALUE_W-1:0]   quot;
  logic [VALUE_W-1:0]   rem_full;
  logic [DIG_IDX_W-1:0] rd_idx;
  logic                 out_free;
  logic                 emit_sign;
  logic                 emit_digit;

  assign in_neg   = (in_ch.opcode == OPC_SIGNED) && in_ch.value[VALUE_W-1];
  assign quot     = VALUE_W'(prod_r[PROD_W-1:RECIP_SHIFT]);
  assign rem_full = mag_r - ((quot << 3) + (quot << 1));
  assign rd_idx   = nd_r - DIG_IDX_W'(1);
  assign out_free = !out_valid_r || out_ch.ready;

  assign emit_sign  = ctl.go && (ctl.op == OP_EMIT_SIGN) && neg_r;
  assign emit_digit = ctl.go && (ctl.op == OP_EMIT_DIGIT);

  assign in_ch.ready = (ctl.op == OP_LOAD);

  assign stat.in_avail = in_ch.valid;
  assign stat.out_free = out_free;
  assign stat.neg      = neg_r;
  assign stat.quot_nz  = (quot != '0);
  assign stat.more_dig = (nd_r > DIG_IDX_W'(1));

  always_ff @(posedge clk) begin
    if (ctl.go) begin
      case (ctl.op)
        OP_LOAD: begin
          mag_r <= in_neg ? (VALUE_W'(0) - in_ch.value) : in_ch.value;
          neg_r <= in_neg;
          nd_r  <= '0;
        end
        OP_MUL: begin
          prod_r <= PROD_W'(mag_r) * PROD_W'(RECIP_10);
        end
        OP_DIV: begin
          mag_r       <= quot;
          dig_r[nd_r] <= rem_full[3:0];
          nd_r        <= nd_r + DIG_IDX_W'(1);
          total_r     <= TOTAL_W'(nd_r) + TOTAL_W'(1) + TOTAL_W'(neg_r);
        end
        OP_EMIT_DIGIT: begin
          nd_r <= nd_r - DIG_IDX_W'(1);
        end
        default: begin
        end
      endcase
    end
  end

  // Output register; payload loads only when the slot is free.
  always_ff @(posedge clk) begin
    if (emit_sign) begin
      out_char_r  <= MINUS_CODE;
      out_last_r  <= 1'b0;
      out_total_r <= '0;
    end else if (emit_digit) begin
      out_char_r  <= DIGIT_BASE + CHAR_W'(dig_r[rd_idx]);
      out_last_r  <= (nd_r == DIG_IDX_W'(1));
      out_total_r <= (nd_r == DIG_IDX_W'(1)) ? total_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_sign || emit_digit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.char_code  = out_char_r;
  assign out_ch.is_last    = out_last_r;
  assign out_ch.char_total = out_total_r;

endmodule

[rtl/core/int_to_decimal_ascii_top.sv]
// Top level of the 32-bit binary to decimal ASCII converter.
// Depends on i2d_pkg, the channel interfaces, i2d_seq and i2d_dp.
//
// Each word accepted on in_ch is turned into its decimal text, sent one
// character per word on out_ch, most significant digit first with no leading
// zeros; opcode 0 reads the value as two's complement and puts '-' ahead of a
// negative number, opcode 1 reads it as unsigned. The last character of a run
// has is_last set and carries the run's character count in char_total, which
// is zero on all other characters. One number is handled at a time: a word
// passes through a load step, two microcode steps per digit on the shared
// reciprocal multiplier (multiply, then quotient and remainder), one step for
// the optional sign and one step per digit through the single output register.
// The output register decouples the sides, so a stalled sink only holds the
// emitting steps. Nothing is kept from one number to the next.
module int_to_decimal_ascii_top (
  input  logic      clk,
  input  logic      rst_n,
  i2d_in_if.sink    in_ch,
  i2d_out_if.source out_ch
);
  import i2d_pkg::*;

  dp_ctl_t  ctl;
  dp_stat_t stat;

  // The sequencer steps through a five-word program: load, then a
  // multiply/divide loop that peels off the least significant digit until the
  // quotient is zero, then the sign, then a loop that plays the stored digits
  // back from the most significant one.
  i2d_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctl   (ctl)
  );

  // The datapath holds the magnitude, the digit buffer and the output register.
  i2d_dp u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .stat   (stat),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule
